### hw/rtl/gsl_pkg.sv
// Shared types, codes and constant tables for the surface layout calculator.
`timescale 1ns / 1ps

package gsl_pkg;

    // Request word as it arrives on the input channel
    typedef struct packed {
        logic [14:0] width_px;
        logic [14:0] height_px;
        logic [2:0]  bytes_per_pixel;
        logic        sw_access;
        logic        sw_read_often;
        logic        hw_scanout;
        logic        hw_texture;
        logic        hw_render;
    } t_req;

    // Result word as it leaves on the output channel
    typedef struct packed {
        logic [1:0]  status;
        logic        tiled;
        logic [16:0] pitch_bytes;
        logic [30:0] size_bytes;
        logic [9:0]  start_align_bytes;
        logic        in_gtt;
    } t_rsp;

    // Status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_TILE = 2'd1;
    localparam logic [1:0] STATUS_BAD_BPP  = 2'd2;

    // Register indexes (byte address bits [3:2])
    localparam int unsigned CFG_ADDR_W = 4;
    localparam logic [1:0] REG_TILE_WORD      = 2'd0;
    localparam logic [1:0] REG_NEWER_LAYOUT   = 2'd1;
    localparam logic [1:0] REG_TILING_KNOWN   = 2'd2;
    localparam logic [1:0] REG_TILING_WITH_SW = 2'd3;

    // Configuration register set
    typedef struct packed {
        logic [11:0] tile_word;
        logic        newer_layout;
        logic        tiling_known;
        logic        tiling_with_sw;
    } t_cfg;

    // Pitch alignment: ((div85 ? 85 : 1) << shift), with m1 = alignment - 1
    typedef struct packed {
        logic       div85;
        logic [3:0] shift;
        logic [8:0] m1;
    } t_align;

    // Fields that ride along the pipeline untouched
    typedef struct packed {
        logic [1:0] status;
        logic       tiled;
        logic [9:0] start_align;
        logic       in_gtt;
    } t_meta;

    // Classified job held in the queue between front and back
    typedef struct packed {
        t_meta       meta;
        logic        pad;
        t_align      align;
        logic [14:0] w;
        logic [14:0] h;
        logic [2:0]  bpp;
    } t_job;

    // Queue depth between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;

    // floor(v / 85) = (v * RECIP85) >> RECIP85_SHIFT, exact for v < 2^16
    localparam logic [15:0] RECIP85       = 16'd49345;
    localparam int unsigned RECIP85_SHIFT = 22;
    localparam logic [22:0] MUL85         = 23'd85;

    // Saturation limits of the result fields
    localparam logic [17:0] PITCH_MAX = 18'h1FFFF;
    localparam logic [30:0] SIZE_MAX  = 31'h7FFFFFFF;

    // Pitch alignment in pixels from group size and pixel size: group / bpp
    function automatic t_align align_lookup(input logic g512, input logic [2:0] bpp);
        t_align a;
        a = '{div85: 1'b0, shift: 4'd0, m1: 9'd0};
        case ({g512, bpp})
            4'b0_001: a = '{div85: 1'b0, shift: 4'd8, m1: 9'd255};
            4'b0_010: a = '{div85: 1'b0, shift: 4'd7, m1: 9'd127};
            4'b0_011: a = '{div85: 1'b1, shift: 4'd0, m1: 9'd84};
            4'b0_100: a = '{div85: 1'b0, shift: 4'd6, m1: 9'd63};
            4'b1_001: a = '{div85: 1'b0, shift: 4'd9, m1: 9'd511};
            4'b1_010: a = '{div85: 1'b0, shift: 4'd8, m1: 9'd255};
            4'b1_011: a = '{div85: 1'b1, shift: 4'd1, m1: 9'd169};
            4'b1_100: a = '{div85: 1'b0, shift: 4'd7, m1: 9'd127};
            default:  a = '{div85: 1'b0, shift: 4'd0, m1: 9'd0};
        endcase
        return a;
    endfunction

endpackage

### hw/rtl/gsl_cfg.sv
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module gsl_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gsl_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output gsl_pkg::t_cfg                   o_cfg
);

    gsl_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tile_word      <= 12'd0;
            r_cfg.newer_layout   <= 1'b1;
            r_cfg.tiling_known   <= 1'b1;
            r_cfg.tiling_with_sw <= 1'b0;
        end else if (wr_en) begin
            case (paddr[3:2])
                gsl_pkg::REG_TILE_WORD:      r_cfg.tile_word      <= pwdata[11:0];
                gsl_pkg::REG_NEWER_LAYOUT:   r_cfg.newer_layout   <= pwdata[0];
                gsl_pkg::REG_TILING_KNOWN:   r_cfg.tiling_known   <= pwdata[0];
                gsl_pkg::REG_TILING_WITH_SW: r_cfg.tiling_with_sw <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (paddr[3:2])
            gsl_pkg::REG_TILE_WORD:      prdata = {20'd0, r_cfg.tile_word};
            gsl_pkg::REG_NEWER_LAYOUT:   prdata = {31'd0, r_cfg.newer_layout};
            gsl_pkg::REG_TILING_KNOWN:   prdata = {31'd0, r_cfg.tiling_known};
            gsl_pkg::REG_TILING_WITH_SW: prdata = {31'd0, r_cfg.tiling_with_sw};
            default:                     prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/gsl_front.sv
// Front end: decodes the tile word and classifies each request into a job.
`timescale 1ns / 1ps

module gsl_front (
    input  gsl_pkg::t_req i_req,
    input  gsl_pkg::t_cfg i_cfg,
    output gsl_pkg::t_job o_job
);

    logic          bad_tile;
    logic          g512;
    logic          bpp_ok;
    logic          tiled;
    logic          pad;
    gsl_pkg::t_align align;

    // Decode channel, bank and group codes in the selected layout
    always_comb begin
        if (i_cfg.newer_layout) begin
            bad_tile = (i_cfg.tile_word[3:0] > 4'd3) || (i_cfg.tile_word[7:4] > 4'd2)
                    || (i_cfg.tile_word[11:8] > 4'd1);
            g512     = i_cfg.tile_word[8];
        end else begin
            bad_tile = (i_cfg.tile_word[3:1] > 3'd3) || (i_cfg.tile_word[5:4] > 2'd1)
                    || (i_cfg.tile_word[7:6] > 2'd1);
            g512     = i_cfg.tile_word[6];
        end
    end

    assign bpp_ok = (i_req.bytes_per_pixel != 3'd0) && (i_req.bytes_per_pixel <= 3'd4);
    assign tiled  = !(i_req.sw_access && !i_cfg.tiling_with_sw);
    assign pad    = i_req.hw_scanout || i_req.hw_texture;

    // Pick the pitch alignment; unpadded requests get an alignment of one
    always_comb begin
        if (!pad) begin
            align = '{div85: 1'b0, shift: 4'd0, m1: 9'd0};
        end else if (!tiled && !i_cfg.tiling_known) begin
            align = '{div85: 1'b0, shift: 4'd9, m1: 9'd511};
        end else begin
            align = gsl_pkg::align_lookup(g512, i_req.bytes_per_pixel);
        end
    end

    // Build the job word
    always_comb begin
        if (bad_tile) begin
            o_job.meta.status = gsl_pkg::STATUS_BAD_TILE;
        end else if (!bpp_ok) begin
            o_job.meta.status = gsl_pkg::STATUS_BAD_BPP;
        end else begin
            o_job.meta.status = gsl_pkg::STATUS_OK;
        end
        o_job.meta.tiled       = tiled;
        o_job.meta.start_align = (i_cfg.tiling_known && !g512) ? 10'd256 : 10'd512;
        o_job.meta.in_gtt      = !(i_req.hw_scanout || i_req.hw_render) && i_req.sw_read_often;
        o_job.pad              = pad;
        o_job.align            = align;
        o_job.w                = i_req.width_px;
        o_job.h                = i_req.height_px;
        o_job.bpp              = i_req.bytes_per_pixel;
    end

endmodule

### hw/rtl/gsl_queue.sv
// Short job queue that decouples the front end from the arithmetic pipeline.
`timescale 1ns / 1ps

module gsl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gsl_pkg::t_job i_job,
    input  logic          i_pop,
    output gsl_pkg::t_job o_head,
    output logic          o_valid,
    output logic          o_full
);

    gsl_pkg::t_job             r_mem [gsl_pkg::QDEPTH];
    logic [gsl_pkg::QPTR_W-1:0] r_wr;
    logic [gsl_pkg::QPTR_W-1:0] r_rd;
    logic [gsl_pkg::QPTR_W:0]   r_count;
    logic                       do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (gsl_pkg::QPTR_W + 1)'(gsl_pkg::QDEPTH));
    assign do_pop  = i_pop && o_valid;
    assign o_head  = r_mem[r_rd];

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue pushed while full");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue occupancy did not follow a push");

endmodule

### hw/rtl/gsl_back.sv
// Back end: pads width and height, forms pitch and page-rounded size.
`timescale 1ns / 1ps

module gsl_back #(
    parameter int unsigned PAGE_BYTES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gsl_pkg::t_job i_head,
    input  logic          i_head_valid,
    output logic          o_pop,
    output gsl_pkg::t_rsp o_rsp,
    output logic          o_valid,
    input  logic          i_stall
);

    // Page rounding: floor(v / PAGE_BYTES) = (v * RECIP) >> 48 for v < 2^32
    localparam int unsigned PAGE_W  = $clog2(PAGE_BYTES + 1);
    localparam int unsigned Q_W     = 33 - $clog2(PAGE_BYTES);
    localparam int unsigned PROD_W  = Q_W + PAGE_W;
    localparam logic [63:0] RECIP   = ((64'd1 << 48) + 64'(PAGE_BYTES) - 64'd1)
                                      / 64'(PAGE_BYTES);
    localparam logic [23:0] RECIP_LO = RECIP[23:0];
    localparam logic [16:0] RECIP_HI = RECIP[40:24];
    localparam logic [31:0] PAGE_M1  = 32'(PAGE_BYTES - 1);

    logic        advance;
    logic [9:1]  r_v;
    gsl_pkg::t_meta r_meta [1:9];

    // Stage registers
    logic [15:0] r1_vw, r2_vw;
    logic [15:0] r1_hp, r2_hp, r3_hp, r4_hp, r5_hp;
    logic        r1_div85, r2_div85, r3_div85;
    logic [3:0]  r1_shift, r2_shift, r3_shift;
    logic [2:0]  r1_bpp, r2_bpp, r3_bpp, r4_bpp;
    logic [31:0] r2_prod;
    logic [15:0] r3_q;
    logic [15:0] r4_wpad;
    logic [17:0] r5_pitch, r6_pitch, r7_pitch, r8_pitch, r9_pitch;
    logic [33:0] r6_area;
    logic        r7_big, r8_big, r9_big;
    logic [31:0] r7_v;
    logic [55:0] r8_pl;
    logic [48:0] r8_ph;
    logic [Q_W-1:0] r9_q;
    gsl_pkg::t_rsp  r_out;
    logic           r_out_valid;

    // Combinational values between stages
    logic [15:0]     n3_d;
    logic [22:0]     n4_mq;
    logic [31:0]     n4_sh;
    logic [73:0]     n9_sum;
    logic [PROD_W-1:0] n_size;
    logic            n_size_sat;
    logic [16:0]     n_pitch;

    // Whole pipeline moves when the output register is free or being taken
    assign advance = !r_out_valid || !i_stall;
    assign o_pop   = advance && i_head_valid;

    assign n3_d   = r2_div85 ? {6'd0, r2_prod[gsl_pkg::RECIP85_SHIFT +: 10]} : r2_vw;
    assign n4_mq  = r3_div85 ? ({7'd0, r3_q} * gsl_pkg::MUL85) : {7'd0, r3_q};
    assign n4_sh  = {9'd0, n4_mq} << r3_shift;
    assign n9_sum = {1'b0, r8_ph, 24'd0} + {18'd0, r8_pl};
    assign n_size = PROD_W'(r9_q) * PROD_W'(PAGE_BYTES);
    assign n_size_sat = r9_big || (n_size > PROD_W'(gsl_pkg::SIZE_MAX));
    assign n_pitch = (r9_pitch > gsl_pkg::PITCH_MAX) ? gsl_pkg::PITCH_MAX[16:0]
                                                     : r9_pitch[16:0];

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_v         <= {r_v[8:1], i_head_valid};
            r_out_valid <= r_v[9];
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (advance) begin
            // stage 1: add alignment minus one, pad height to eight rows
            r_meta[1] <= i_head.meta;
            r1_vw     <= {1'b0, i_head.w} + {7'd0, i_head.align.m1};
            r1_hp     <= i_head.pad ? (({1'b0, i_head.h} + 16'd7) & 16'hFFF8)
                                    : {1'b0, i_head.h};
            r1_div85  <= i_head.align.div85;
            r1_shift  <= i_head.align.shift;
            r1_bpp    <= i_head.bpp;
            // stage 2: reciprocal product for division by 85
            r_meta[2] <= r_meta[1];
            r2_prod   <= r1_vw * gsl_pkg::RECIP85;
            r2_vw     <= r1_vw;
            r2_hp     <= r1_hp;
            r2_div85  <= r1_div85;
            r2_shift  <= r1_shift;
            r2_bpp    <= r1_bpp;
            // stage 3: quotient in alignment units
            r_meta[3] <= r_meta[2];
            r3_q      <= n3_d >> r2_shift;
            r3_hp     <= r2_hp;
            r3_div85  <= r2_div85;
            r3_shift  <= r2_shift;
            r3_bpp    <= r2_bpp;
            // stage 4: padded width in pixels
            r_meta[4] <= r_meta[3];
            r4_wpad   <= n4_sh[15:0];
            r4_hp     <= r3_hp;
            r4_bpp    <= r3_bpp;
            // stage 5: pitch in bytes
            r_meta[5] <= r_meta[4];
            r5_pitch  <= {2'd0, r4_wpad} * {15'd0, r4_bpp};
            r5_hp     <= r4_hp;
            // stage 6: surface area in bytes
            r_meta[6] <= r_meta[5];
            r6_area   <= {18'd0, r5_hp} * {16'd0, r5_pitch};
            r6_pitch  <= r5_pitch;
            // stage 7: flag oversize, bias for rounding up
            r_meta[7] <= r_meta[6];
            r7_big    <= |r6_area[33:31];
            r7_v      <= {1'b0, r6_area[30:0]} + PAGE_M1;
            r7_pitch  <= r6_pitch;
            // stage 8: partial products of the page reciprocal
            r_meta[8] <= r_meta[7];
            r8_pl     <= {24'd0, r7_v} * {32'd0, RECIP_LO};
            r8_ph     <= {17'd0, r7_v} * {32'd0, RECIP_HI};
            r8_big    <= r7_big;
            r8_pitch  <= r7_pitch;
            // stage 9: page count
            r_meta[9] <= r_meta[8];
            r9_q      <= n9_sum[48 +: Q_W];
            r9_big    <= r8_big;
            r9_pitch  <= r8_pitch;
        end
    end

    // Output register: saturate, zero all fields but the status on an error status
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.status <= r_meta[9].status;
            if (r_meta[9].status == gsl_pkg::STATUS_OK) begin
                r_out.tiled             <= r_meta[9].tiled;
                r_out.pitch_bytes       <= n_pitch;
                r_out.size_bytes        <= n_size_sat ? gsl_pkg::SIZE_MAX : n_size[30:0];
                r_out.start_align_bytes <= r_meta[9].start_align;
                r_out.in_gtt            <= r_meta[9].in_gtt;
            end else begin
                r_out.tiled             <= 1'b0;
                r_out.pitch_bytes       <= 17'd0;
                r_out.size_bytes        <= 31'd0;
                r_out.start_align_bytes <= 10'd0;
                r_out.in_gtt            <= 1'b0;
            end
        end
    end

    assign o_rsp   = r_out;
    assign o_valid = r_out_valid;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != gsl_pkg::STATUS_OK))
        |-> (r_out.pitch_bytes == 17'd0 && r_out.size_bytes == 31'd0 && !r_out.tiled))
        else $error("error result carries nonzero fields");

    a_align_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == gsl_pkg::STATUS_OK))
        |-> (r_out.start_align_bytes == 10'd256 || r_out.start_align_bytes == 10'd512))
        else $error("base alignment out of its set");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_v) && $stable(r_out)))
        else $error("pipeline moved while output stalled");

endmodule

### hw/rtl/gpu_surface_layout_calc.sv
// Top level of the surface layout calculator.
`timescale 1ns / 1ps
//
// Takes one buffer request word (width, height, bytes per pixel, usage flags)
// on the input channel and returns one result word (status, tiling choice,
// pitch, page-rounded size, base alignment, memory domain) on the output.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. Tiling setup must be written through the APB-style port only
// while no request is in flight; the block itself does not enforce this.
// pready is tied high and reads return the register. A result passes the
// job queue, then the nine arithmetic stages, then the output register.
// Throughput: one request per cycle while the receiver does not stall,
// set by the fully pipelined back end.
// When the receiver stalls, the pipeline freezes and the four-entry queue
// keeps taking requests until full, then stall is raised on the input.
// Reset clears the queue, all valid bits and restores register defaults;
// no clearing pass is needed.

module gpu_surface_layout_calc #(
    parameter int unsigned PAGE_BYTES = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  gsl_pkg::t_req                  i_req,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output gsl_pkg::t_rsp                  o_rsp,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gsl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    gsl_pkg::t_cfg cfg;
    gsl_pkg::t_job job;
    gsl_pkg::t_job head;
    logic          head_valid;
    logic          q_full;
    logic          push;
    logic          pop;

    assign push       = i_in_valid && !q_full;
    assign o_in_stall = q_full;

    gsl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gsl_front u_front (
        .i_req (i_req),
        .i_cfg (cfg),
        .o_job (job)
    );

    gsl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_valid (head_valid),
        .o_full  (q_full)
    );

    gsl_back #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_rsp        (o_rsp),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall)
    );

endmodule

### verif/tb.sv
// Self-checking testbench for the surface layout calculator.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned PAGE_BYTES = 4096;
    localparam int unsigned RAND_PER_SETUP = 240;
    localparam int unsigned LONG_HOLD_AT = 300;
    localparam int unsigned LONG_HOLD_CYCLES = 120;

    // Usage flags in request order: sw_access, sw_read_often, scanout, texture, render
    localparam logic [4:0] F_NONE  = 5'b00000;
    localparam logic [4:0] F_SW    = 5'b10000;
    localparam logic [4:0] F_OFTEN = 5'b01000;
    localparam logic [4:0] F_SCAN  = 5'b00100;
    localparam logic [4:0] F_TEX   = 5'b00010;
    localparam logic [4:0] F_REND  = 5'b00001;

    localparam gsl_pkg::t_rsp RSP_BAD_TILE = '{status: gsl_pkg::STATUS_BAD_TILE, default: '0};
    localparam gsl_pkg::t_rsp RSP_BAD_BPP  = '{status: gsl_pkg::STATUS_BAD_BPP, default: '0};

    typedef enum logic {PLAN_REQ, PLAN_CFG} t_plan_kind;

    typedef struct {
        t_plan_kind    kind;
        logic [1:0]    reg_idx;
        logic [11:0]   reg_val;
        gsl_pkg::t_req req;
        logic          typed;
        gsl_pkg::t_rsp rsp;
    } t_plan_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    gsl_pkg::t_req                  i_req = '0;
    logic                           o_out_valid;
    logic                           i_out_stall;
    gsl_pkg::t_rsp                  o_rsp;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [gsl_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    gsl_pkg::t_cfg cfg_shadow;
    gsl_pkg::t_rsp due_layouts[$];
    t_plan_row     plan[$];
    int unsigned n_sent = 0;
    int unsigned n_words = 0;
    int unsigned n_err = 0;
    int unsigned n_writes = 0;
    int unsigned rx_hold = 0;
    int unsigned long_left = 0;
    logic        long_done = 1'b0;
    logic        rx_stall = 1'b0;
    logic        long_stall = 1'b0;
    logic        rx_burst = 1'b0;
    logic        tx_burst = 1'b0;

    assign i_out_stall = rx_stall || long_stall;

    gpu_surface_layout_calc #(
        .PAGE_BYTES(PAGE_BYTES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_req      (i_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_rsp      (o_rsp),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    // Round up to a true multiple, so non power-of-two steps work
    function automatic longint unsigned ceil_to(input longint unsigned v,
                                                input longint unsigned step);
        if (step == 0) return v;
        return ((v + step - 1) / step) * step;
    endfunction

    // Compute the expected layout word for one request under a register set
    function automatic gsl_pkg::t_rsp predict_layout(input gsl_pkg::t_cfg c,
                                                     input gsl_pkg::t_req r);
        gsl_pkg::t_rsp   o;
        logic [3:0]      chan;
        logic [3:0]      bank;
        logic [3:0]      gcode;
        logic            word_ok;
        logic            tl;
        int unsigned     grp;
        int unsigned     bpp;
        int unsigned     palign;
        longint unsigned w;
        longint unsigned h;
        longint unsigned pitch;
        longint unsigned area;
        o = '0;
        if (c.newer_layout) begin
            chan  = c.tile_word[3:0];
            bank  = c.tile_word[7:4];
            gcode = c.tile_word[11:8];
            word_ok = (chan <= 3) && (bank <= 2) && (gcode <= 1);
        end else begin
            chan  = {1'b0, c.tile_word[3:1]};
            bank  = {2'b00, c.tile_word[5:4]};
            gcode = {2'b00, c.tile_word[7:6]};
            word_ok = (chan <= 3) && (bank <= 1) && (gcode <= 1);
        end
        grp = gcode[0] ? 512 : 256;
        bpp = r.bytes_per_pixel;
        if (!word_ok) begin
            o.status = gsl_pkg::STATUS_BAD_TILE;
        end else if (bpp == 0 || bpp > 4) begin
            o.status = gsl_pkg::STATUS_BAD_BPP;
        end else begin
            tl = !(r.sw_access && !c.tiling_with_sw);
            // Pitch alignment in pixels
            if (tl) begin
                palign = (grp / (8 * bpp) > 8) ? grp / (8 * bpp) : 8;
                if (grp / bpp > palign) palign = grp / bpp;
            end else if (c.tiling_known) begin
                palign = (grp / bpp > 64) ? grp / bpp : 64;
            end else begin
                palign = 512;
            end
            w = r.width_px;
            h = r.height_px;
            if (r.hw_scanout || r.hw_texture) begin
                w = ceil_to(w, palign);
                h = ceil_to(h, 8);
            end
            pitch = w * bpp;
            area  = ceil_to(h * pitch, PAGE_BYTES);
            o.status            = gsl_pkg::STATUS_OK;
            o.tiled             = tl;
            o.pitch_bytes       = (pitch > 64'h1FFFF) ? '1 : pitch[16:0];
            o.size_bytes        = (area > 64'h7FFFFFFF) ? '1 : area[30:0];
            o.start_align_bytes = c.tiling_known ? grp[9:0] : 10'd512;
            o.in_gtt            = !(r.hw_scanout || r.hw_render) && r.sw_read_often;
        end
        return o;
    endfunction

    function automatic gsl_pkg::t_req mk_req(input int unsigned w, input int unsigned h,
                                             input int unsigned b, input logic [4:0] f);
        gsl_pkg::t_req r;
        r.width_px        = w[14:0];
        r.height_px       = h[14:0];
        r.bytes_per_pixel = b[2:0];
        {r.sw_access, r.sw_read_often, r.hw_scanout, r.hw_texture, r.hw_render} = f;
        return r;
    endfunction

    function automatic t_plan_row req_row(input gsl_pkg::t_req r);
        t_plan_row p;
        p = '{kind: PLAN_REQ, reg_idx: '0, reg_val: '0, req: r, typed: 1'b0, rsp: '0};
        return p;
    endfunction

    function automatic t_plan_row chk_row(input gsl_pkg::t_req r, input gsl_pkg::t_rsp e);
        t_plan_row p;
        p = '{kind: PLAN_REQ, reg_idx: '0, reg_val: '0, req: r, typed: 1'b1, rsp: e};
        return p;
    endfunction

    function automatic t_plan_row cfg_row(input logic [1:0] idx, input logic [11:0] v);
        t_plan_row p;
        p = '{kind: PLAN_CFG, reg_idx: idx, reg_val: v, req: '0, typed: 1'b0, rsp: '0};
        return p;
    endfunction

    // Mostly small sizes, some full range, some around the nominal maximum
    function automatic int unsigned pick_dim();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 32767);
            1:       return $urandom_range(16376, 16392);
            2:       return $urandom_range(0, 8);
            default: return $urandom_range(0, 700);
        endcase
    endfunction

    function automatic gsl_pkg::t_req rand_req();
        int unsigned b;
        b = ($urandom_range(0, 15) < 2) ? $urandom_range(0, 7) : $urandom_range(1, 4);
        return mk_req(pick_dim(), pick_dim(), b, 5'($urandom));
    endfunction

    // Mostly a valid tile word for the chosen layout, sometimes any 12 bits
    function automatic logic [11:0] pick_tile_word(input logic newer);
        if ($urandom_range(0, 3) == 0) return 12'($urandom);
        if (newer)
            return {4'($urandom_range(0, 1)), 4'($urandom_range(0, 2)),
                    4'($urandom_range(0, 3))};
        return {4'($urandom), 2'($urandom_range(0, 1)), 2'($urandom_range(0, 1)),
                1'b0, 2'($urandom), 1'($urandom)};
    endfunction

    // Offer one request word until taken, then rest for the given gap
    task automatic send_req(input gsl_pkg::t_req r, input gsl_pkg::t_rsp want,
                            input int unsigned gap);
        i_req      <= r;
        i_in_valid <= 1'b1;
        due_layouts.push_back(want);
        n_sent++;
        do @(posedge i_clk); while (o_in_stall);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait for every pending result word
    task automatic drain_words();
        i_in_valid <= 1'b0;
        while (due_layouts.size() != 0) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at its end
    task automatic cfg_write(input logic [1:0] idx, input logic [11:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {20'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            gsl_pkg::REG_TILE_WORD:      cfg_shadow.tile_word      = v;
            gsl_pkg::REG_NEWER_LAYOUT:   cfg_shadow.newer_layout   = v[0];
            gsl_pkg::REG_TILING_KNOWN:   cfg_shadow.tiling_known   = v[0];
            gsl_pkg::REG_TILING_WITH_SW: cfg_shadow.tiling_with_sw = v[0];
            default: ;
        endcase
        n_writes++;
        // Idle before returning so the next transfer starts on a fresh edge
        @(posedge i_clk);
    endtask

    function automatic int unsigned tx_gap();
        if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
        return tx_burst ? 0 : $urandom_range(0, 9);
    endfunction

    // Receive side: check each word, then stall for a drawn number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_stall <= 1'b0;
            rx_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (due_layouts.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("%0t: result word with no request pending: %h", $time, o_rsp);
                end else begin
                    gsl_pkg::t_rsp want;
                    want = due_layouts.pop_front();
                    if (o_rsp.status !== want.status || o_rsp.tiled !== want.tiled ||
                        o_rsp.pitch_bytes !== want.pitch_bytes ||
                        o_rsp.size_bytes !== want.size_bytes ||
                        o_rsp.start_align_bytes !== want.start_align_bytes ||
                        o_rsp.in_gtt !== want.in_gtt) begin
                        n_err++;
                        if (n_err <= 10) begin
                            $display("%0t: word %0d mismatch (expected / actual)", $time, n_words);
                            $display("  status %0d/%0d tiled %0d/%0d pitch %0d/%0d",
                                     want.status, o_rsp.status, want.tiled, o_rsp.tiled,
                                     want.pitch_bytes, o_rsp.pitch_bytes);
                            $display("  size %0d/%0d align %0d/%0d gtt %0d/%0d",
                                     want.size_bytes, o_rsp.size_bytes,
                                     want.start_align_bytes, o_rsp.start_align_bytes,
                                     want.in_gtt, o_rsp.in_gtt);
                        end
                    end
                end
                n_words++;
                if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
                rx_hold = rx_burst ? 0 : $urandom_range(0, 9);
            end
            if (rx_hold > 0) begin
                rx_stall <= 1'b1;
                rx_hold--;
            end else begin
                rx_stall <= 1'b0;
            end
        end
    end

    // Hold off once for long enough to fill the pipeline and the queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            long_stall <= 1'b0;
            long_left = 0;
            long_done = 1'b0;
        end else begin
            if (!long_done && n_words >= LONG_HOLD_AT) begin
                long_done = 1'b1;
                long_left = LONG_HOLD_CYCLES;
            end
            if (long_left > 0) begin
                long_stall <= 1'b1;
                long_left--;
            end else begin
                long_stall <= 1'b0;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d result words still pending", due_layouts.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic newer;
        logic [11:0] tw;
        cfg_shadow = '{tile_word: 12'd0, newer_layout: 1'b1, tiling_known: 1'b1,
                       tiling_with_sw: 1'b0};

        // Reset setup: newer layout, tile word 0, group of 256 bytes
        plan.push_back(chk_row(mk_req(0, 0, 1, F_NONE),
                               gsl_pkg::t_rsp'{gsl_pkg::STATUS_OK, 1'b1, 17'd0, 31'd0,
                                               10'd256, 1'b0}));
        plan.push_back(chk_row(mk_req(100, 100, 0, F_TEX), RSP_BAD_BPP));
        plan.push_back(chk_row(mk_req(32767, 32767, 7, 5'b11111), RSP_BAD_BPP));
        plan.push_back(chk_row(mk_req(1, 1, 5, F_SCAN), RSP_BAD_BPP));
        // Oversize: both pitch and size saturate
        plan.push_back(chk_row(mk_req(32767, 32767, 4, F_SCAN),
                               gsl_pkg::t_rsp'{gsl_pkg::STATUS_OK, 1'b1, 17'h1FFFF,
                                               31'h7FFFFFFF, 10'd256, 1'b0}));
        plan.push_back(req_row(mk_req(16384, 16384, 4, F_TEX)));
        plan.push_back(req_row(mk_req(1, 1, 3, F_TEX)));
        plan.push_back(req_row(mk_req(333, 17, 2, F_SW | F_OFTEN | F_TEX)));
        plan.push_back(req_row(mk_req(5, 5, 1, F_OFTEN | F_REND)));
        plan.push_back(req_row(mk_req(77, 9, 4, F_OFTEN)));
        // Tiling allowed with software access
        plan.push_back(cfg_row(gsl_pkg::REG_TILING_WITH_SW, 12'd1));
        plan.push_back(req_row(mk_req(100, 7, 3, F_SW | F_SCAN)));
        // Group of 512 bytes
        plan.push_back(cfg_row(gsl_pkg::REG_TILE_WORD, 12'h100));
        plan.push_back(req_row(mk_req(513, 9, 1, F_TEX)));
        // Unknown group size, linear
        plan.push_back(cfg_row(gsl_pkg::REG_TILING_KNOWN, 12'd0));
        plan.push_back(cfg_row(gsl_pkg::REG_TILING_WITH_SW, 12'd0));
        plan.push_back(req_row(mk_req(1, 1, 4, F_SW | F_TEX)));
        plan.push_back(req_row(mk_req(700, 3, 3, F_SW | F_SCAN | F_OFTEN)));
        // Invalid tile word wins over a bad pixel size
        plan.push_back(cfg_row(gsl_pkg::REG_TILE_WORD, 12'h004));
        plan.push_back(chk_row(mk_req(10, 10, 0, F_TEX), RSP_BAD_TILE));
        plan.push_back(cfg_row(gsl_pkg::REG_TILE_WORD, 12'h030));
        plan.push_back(chk_row(mk_req(10, 10, 2, F_TEX), RSP_BAD_TILE));
        plan.push_back(cfg_row(gsl_pkg::REG_TILE_WORD, 12'h200));
        plan.push_back(chk_row(mk_req(10, 10, 2, F_NONE), RSP_BAD_TILE));
        // Older layout: valid word with group of 512, then bad bank and group codes
        plan.push_back(cfg_row(gsl_pkg::REG_NEWER_LAYOUT, 12'd0));
        plan.push_back(cfg_row(gsl_pkg::REG_TILING_KNOWN, 12'd1));
        plan.push_back(cfg_row(gsl_pkg::REG_TILE_WORD, 12'h046));
        plan.push_back(req_row(mk_req(200, 33, 3, F_SCAN | F_OFTEN)));
        plan.push_back(cfg_row(gsl_pkg::REG_TILE_WORD, 12'h020));
        plan.push_back(chk_row(mk_req(4, 4, 1, F_TEX), RSP_BAD_TILE));
        plan.push_back(cfg_row(gsl_pkg::REG_TILE_WORD, 12'h080));
        plan.push_back(chk_row(mk_req(4, 4, 1, F_TEX), RSP_BAD_TILE));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (plan[k]) begin
            if (plan[k].kind == PLAN_CFG) begin
                drain_words();
                cfg_write(plan[k].reg_idx, plan[k].reg_val);
            end else begin
                send_req(plan[k].req,
                         plan[k].typed ? plan[k].rsp : predict_layout(cfg_shadow, plan[k].req),
                         tx_gap());
            end
        end

        // Random requests under every flag combination, tile word extremes included
        for (int unsigned ph = 0; ph < 8; ph++) begin
            drain_words();
            newer = ph[0];
            tw = (ph == 1) ? 12'hFFF : (ph == 6) ? 12'h000 : pick_tile_word(newer);
            cfg_write(gsl_pkg::REG_NEWER_LAYOUT, {11'd0, newer});
            cfg_write(gsl_pkg::REG_TILE_WORD, tw);
            cfg_write(gsl_pkg::REG_TILING_KNOWN, {11'd0, ph[1]});
            cfg_write(gsl_pkg::REG_TILING_WITH_SW, {11'd0, ph[2]});
            repeat (RAND_PER_SETUP) begin
                gsl_pkg::t_req r;
                r = rand_req();
                send_req(r, predict_layout(cfg_shadow, r), tx_gap());
            end
        end

        drain_words();
        repeat (30) @(posedge i_clk);
        $display("Sent %0d requests (%0d directed rows) across %0d register writes,",
                 n_sent, plan.size(), n_writes);
        $display("checked %0d result words, %0d mismatches.", n_words, n_err);
        if (n_err == 0 && due_layouts.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
